/* rtl/tbl_pkg.sv */
package tbl_pkg;

    typedef enum logic [2:0] {
        PH_LEN_LO = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_FLAG   = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CFG_FLAG    = 2'd0,
        CFG_LOAD    = 2'd1,
        CFG_LENGTH  = 2'd2
    } cfg_index_t;

    localparam logic [16:0] BLOCK_OVERHEAD = 17'd2;

    typedef struct packed {
        logic [7:0]  flag;
        logic [15:0] load;
        logic [15:0] length;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [7:0]  data;
        status_t     status;
    } result_t;

endpackage

/* rtl/tbl_parser.sv */
module tbl_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [7:0]       byte_in,
    input  tbl_pkg::cfg_t    cfg,
    output logic             res_valid,
    output tbl_pkg::result_t res
);
    import tbl_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] len_word;
    logic        mismatch;

    assign len_word = {byte_in, len_reg[7:0]};
    assign mismatch = (byte_in != cfg.flag) ||
                      ({1'b0, len_reg} != ({1'b0, cfg.length} + BLOCK_OVERHEAD));

    // next state and datapath
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        left_next  = left_reg;
        addr_next  = addr_reg;
        unique case (phase_reg)
            PH_LEN_HI:
            begin
                len_next   = len_word;
                phase_next = (len_word == 16'd0) ? PH_LEN_LO : PH_FLAG;
            end
            PH_FLAG:
            begin
                if (mismatch)
                begin
                    left_next  = len_reg - 16'd1;
                    phase_next = (len_reg == 16'd1) ? PH_LEN_LO : PH_SKIP;
                end
                else
                begin
                    xor_next   = byte_in;
                    addr_next  = cfg.load;
                    left_next  = cfg.length;
                    phase_next = (cfg.length == 16'd0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA:
            begin
                xor_next  = xor_reg ^ byte_in;
                addr_next = addr_reg + 16'd1;
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                phase_next = PH_LEN_LO;
            end
            PH_SKIP:
            begin
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = PH_LEN_LO;
                end
            end
            default:
            begin
                len_next   = {8'd0, byte_in};
                phase_next = PH_LEN_HI;
            end
        endcase
    end

    // result outputs
    always_comb
    begin
        res_valid  = 1'b0;
        res.kind   = KIND_STATUS;
        res.addr   = 16'd0;
        res.data   = 8'd0;
        res.status = ST_OK;
        unique case (phase_reg)
            PH_LEN_HI:
            begin
                if (len_word == 16'd0)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_MISMATCH;
                end
            end
            PH_FLAG:
            begin
                if (mismatch)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_MISMATCH;
                end
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_WRITE;
                res.addr  = addr_reg;
                res.data  = byte_in;
            end
            PH_CHECK:
            begin
                res_valid  = 1'b1;
                res.status = (byte_in == xor_reg) ? ST_OK : ST_CHECKSUM;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_LO;
            len_reg   <= 16'd0;
            xor_reg   <= 8'd0;
            left_reg  <= 16'd0;
            addr_reg  <= 16'd0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
            left_reg  <= left_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

/* rtl/tbl_out_reg.sv */
module tbl_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tbl_pkg::result_t res,
    input  logic             ready,
    output logic             free,
    output logic             valid,
    output tbl_pkg::result_t res_out
);
    import tbl_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign res_out = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

/* rtl/tape_block_loader_xor_check.sv */
// Tape block loader: parses a stream of tape bytes (length word low byte first, flag, data,
// XOR checksum), emits one memory write per data byte and one status item per block.
// Each tape byte is taken into an input register and decoded by combinational logic into
// an output register, so one byte is accepted per clock while the result output is not
// stalled; each byte gives zero or one result, which reaches the port from the output register.
// Writes leave before the block's checksum verdict, so a consumer discards them on a
// checksum error. Configuration (flag, load address, data length) is sampled at each
// block's flag byte.
module tape_block_loader_xor_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tape_valid,
    output logic        tape_ready,
    input  logic [7:0]  tape_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        result_kind,
    output logic [15:0] write_address,
    output logic [7:0]  write_byte,
    output logic [1:0]  block_status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tbl_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       proc_en;
    logic       res_valid;
    result_t    res;
    result_t    res_out;

    assign proc_en    = in_valid_reg && out_free;
    assign tape_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLAG:   cfg_reg.flag   <= cfg_data[7:0];
                CFG_LOAD:   cfg_reg.load   <= cfg_data;
                CFG_LENGTH: cfg_reg.length <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tape_ready)
        begin
            in_valid_reg <= tape_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tape_valid && tape_ready)
        begin
            in_byte_reg <= tape_byte;
        end
    end

    tbl_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (proc_en),
        .byte_in   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tbl_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (proc_en && res_valid),
        .res     (res),
        .ready   (result_ready),
        .free    (out_free),
        .valid   (result_valid),
        .res_out (res_out)
    );

    assign result_kind   = res_out.kind;
    assign write_address = res_out.addr;
    assign write_byte    = res_out.data;
    assign block_status  = res_out.status;

    // a stalled result holds the byte waiting in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input item lost while output stalled");

    // write items always carry an ok status field
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (res_out.kind == KIND_WRITE) |-> (res_out.status == ST_OK))
        else $error("write item with nonzero status");

    // status items carry only defined codes and no address
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (res_out.kind == KIND_STATUS) |->
            ((res_out.status == ST_OK) || (res_out.status == ST_CHECKSUM) ||
             (res_out.status == ST_MISMATCH)) && (res_out.addr == 16'd0))
        else $error("malformed status item");

endmodule
